>>> sv/scas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scas_pkg
// Shared sizes, types and codes for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package scas_pkg;

   localparam int WAYS      = 8;
   localparam int SETS      = 1024;
   localparam int ADDR_BITS = 48;

   localparam int STAMP_W   = 32;
   localparam int CNT_W     = 32;
   localparam int DIV_W     = 48;   // dividend / quotient width
   localparam int DVS_W     = 32;   // divisor / remainder width
   localparam int SET_AW    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int SET_CNT_W = $clog2(SETS + 1);
   localparam int WAY_IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NWAY_W    = $clog2(WAYS + 1);
   localparam int CSR_AW    = 4;

   localparam logic [1:0] REG_CACHE_BYTES = 2'd0;
   localparam logic [1:0] REG_LINE_BYTES  = 2'd1;
   localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic [STAMP_W-1:0]   stamp;
      logic [ADDR_BITS-1:0] tag;
   } way_type;

   typedef way_type [WAYS-1:0] row_type;

   localparam int ROW_W = $bits(row_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_READ,
      ST_LOOK
   } state_type;

   // divisions run for one access, in this order; OP_CL and OP_W only when the set count must be worked out anew
   typedef enum logic [1:0] {
      OP_CL,     // cache bytes / line bytes
      OP_W,      // previous quotient / ways
      OP_ADDR,   // address / line bytes
      OP_SET     // line % set count
   } op_type;

endpackage

>>> sv/set_assoc_lru_cache_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache with LRU replacement over a byte-address trace.
//
//   channel | ports    | word
//   --------+----------+-------------------------------------------------
//   in      | req_*    | address
//   out     | rsp_*    | hit, way_used, set_index, hit_total, miss_total
//   config  | csr_*    | cache_bytes @0, line_bytes @4, ways_in_use @8
//
// After reset a clearing pass writes all SETS rows before the first word is
// taken. A new word is taken only once the previous word's result has been
// registered. Each word goes through the bit-serial divider (address / line,
// then line % set count); the first access after reset or a config write
// first works out the set count. The set row is read, compared and written
// back through one RAM. A stalled result holds the lookup until the output
// register is free.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [47:0]                   req_tdata,   // address
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // hit[0], way_used[3:1], set_index[13:4], hit_total[45:14],
   // miss_total[77:46], zero pad
   output logic [79:0]                   rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [scas_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import scas_pkg::*;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [31:0]             cache_bytes_ff, cache_bytes_in;
   logic [12:0]             line_bytes_ff, line_bytes_in;
   logic [3:0]              ways_ff, ways_in;
   logic [ADDR_BITS-1:0]    addr_ff, addr_in;
   logic [ADDR_BITS-1:0]    line_ff, line_in;
   logic [31:0]             clq_ff, clq_in;
   logic [SET_CNT_W-1:0]    sets_ff, sets_in;
   logic                    sets_ok_ff, sets_ok_in;
   logic [SET_AW-1:0]       set_ff, set_in;
   logic [SET_AW-1:0]       clr_ff, clr_in;
   logic [STAMP_W-1:0]      clock_ff, clock_in;
   logic [CNT_W-1:0]        hits_ff, hits_in;
   logic [CNT_W-1:0]        misses_ff, misses_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [2:0]              rsp_way_ff, rsp_way_in;
   logic [9:0]              rsp_set_ff, rsp_set_in;
   logic [CNT_W-1:0]        rsp_hits_ff, rsp_hits_in;
   logic [CNT_W-1:0]        rsp_misses_ff, rsp_misses_in;

   logic                    div_start, div_done;
   logic [DIV_W-1:0]        div_dividend;
   logic [DVS_W-1:0]        div_divisor;
   logic [DIV_W-1:0]        div_quo;
   logic [DVS_W-1:0]        div_rem;

   logic                    ram_we, ram_re;
   logic [SET_AW-1:0]       ram_waddr;
   row_type                 ram_wdata, ram_rdata, new_row;

   logic [31:0]             eff_line;
   logic [NWAY_W-1:0]       nways;
   logic                    csr_wr, out_free;
   logic                    hit_any;
   logic [WAY_IW-1:0]       hit_way, vic_way, sel_way;
   logic [STAMP_W-1:0]      min_stamp;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign eff_line   = (line_bytes_ff == '0) ? 32'd1 : {19'd0, line_bytes_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (ways_ff == '0) begin
         nways = NWAY_W'(1);
      end else if (32'(ways_ff) > 32'(WAYS)) begin
         nways = NWAY_W'(WAYS);
      end else begin
         nways = NWAY_W'(ways_ff);
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_CACHE_BYTES: csr_prdata = cache_bytes_ff;
         REG_LINE_BYTES:  csr_prdata = {19'd0, line_bytes_ff};
         REG_WAYS_IN_USE: csr_prdata = {28'd0, ways_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // divider operands follow the current step
   always_comb begin
      unique case (op_ff)
         OP_CL: begin
            div_dividend = DIV_W'(cache_bytes_ff);
            div_divisor  = eff_line;
         end
         OP_W: begin
            div_dividend = DIV_W'(clq_ff);
            div_divisor  = DVS_W'(nways);
         end
         OP_ADDR: begin
            div_dividend = DIV_W'(addr_ff);
            div_divisor  = eff_line;
         end
         OP_SET: begin
            div_dividend = DIV_W'(line_ff);
            div_divisor  = DVS_W'(sets_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = 32'd1;
         end
      endcase
   end

   scas_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .done      (div_done),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // way search over the row just read: first hit, else oldest stamp
   always_comb begin
      hit_any   = 1'b0;
      hit_way   = '0;
      vic_way   = '0;
      min_stamp = ram_rdata[0].stamp;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (NWAY_W'(w) < nways && ram_rdata[w].valid && ram_rdata[w].tag == line_ff) begin
            hit_any = 1'b1;
            hit_way = WAY_IW'(w);
         end
      end
      for (int w = 1; w < WAYS; w++) begin
         if (NWAY_W'(w) < nways && ram_rdata[w].stamp < min_stamp) begin
            min_stamp = ram_rdata[w].stamp;
            vic_way   = WAY_IW'(w);
         end
      end
      sel_way = hit_any ? hit_way : vic_way;
      new_row = ram_rdata;
      new_row[sel_way].stamp = clock_ff;
      if (!hit_any) begin
         new_row[sel_way].tag   = line_ff;
         new_row[sel_way].valid = 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      cache_bytes_in = cache_bytes_ff;
      line_bytes_in  = line_bytes_ff;
      ways_in        = ways_ff;
      addr_in        = addr_ff;
      line_in        = line_ff;
      clq_in         = clq_ff;
      sets_in        = sets_ff;
      sets_ok_in     = sets_ok_ff;
      set_in         = set_ff;
      clr_in         = clr_ff;
      clock_in       = clock_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_way_in     = rsp_way_ff;
      rsp_set_in     = rsp_set_ff;
      rsp_hits_in    = rsp_hits_ff;
      rsp_misses_in  = rsp_misses_ff;
      req_tready     = 1'b0;
      div_start      = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = set_ff;
      ram_wdata      = new_row;
      ram_re         = 1'b0;

      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_CACHE_BYTES: cache_bytes_in = csr_pwdata;
            REG_LINE_BYTES:  line_bytes_in  = csr_pwdata[12:0];
            REG_WAYS_IN_USE: ways_in        = csr_pwdata[3:0];
            default: ;
         endcase
         sets_ok_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == SET_AW'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               addr_in  = req_tdata[ADDR_BITS-1:0];
               op_in    = sets_ok_ff ? OP_ADDR : OP_CL;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               unique case (op_ff)
                  OP_CL: begin
                     clq_in   = div_quo[31:0];
                     op_in    = OP_W;
                     state_in = ST_DIV_GO;
                  end
                  OP_W: begin
                     if (div_quo == '0) begin
                        sets_in = SET_CNT_W'(1);
                     end else if (div_quo > DIV_W'(SETS)) begin
                        sets_in = SET_CNT_W'(SETS);
                     end else begin
                        sets_in = div_quo[SET_CNT_W-1:0];
                     end
                     sets_ok_in = 1'b1;
                     op_in      = OP_ADDR;
                     state_in   = ST_DIV_GO;
                  end
                  OP_ADDR: begin
                     line_in  = div_quo[ADDR_BITS-1:0];
                     op_in    = OP_SET;
                     state_in = ST_DIV_GO;
                  end
                  OP_SET: begin
                     set_in   = div_rem[SET_AW-1:0];
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (out_free) begin
               ram_we = 1'b1;
               if (hit_any) begin
                  hits_in = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
               end else begin
                  misses_in = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
               end
               clock_in      = (clock_ff == '1) ? clock_ff : clock_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = hit_any;
               rsp_way_in    = 3'(sel_way);
               rsp_set_in    = 10'(set_ff);
               rsp_hits_in   = hits_in;
               rsp_misses_in = misses_in;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   scas_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_rows (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (set_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         op_ff          <= OP_CL;
         cache_bytes_ff <= 32'd32768;
         line_bytes_ff  <= 13'd64;
         ways_ff        <= 4'd8;
         sets_ok_ff     <= 1'b0;
         clr_ff         <= '0;
         clock_ff       <= STAMP_W'(1);
         hits_ff        <= '0;
         misses_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         cache_bytes_ff <= cache_bytes_in;
         line_bytes_ff  <= line_bytes_in;
         ways_ff        <= ways_in;
         sets_ok_ff     <= sets_ok_in;
         clr_ff         <= clr_in;
         clock_ff       <= clock_in;
         hits_ff        <= hits_in;
         misses_ff      <= misses_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      line_ff       <= line_in;
      clq_ff        <= clq_in;
      sets_ff       <= sets_in;
      set_ff        <= set_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_set_ff    <= rsp_set_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_misses_ff <= rsp_misses_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_misses_ff, rsp_hits_ff, rsp_set_ff, rsp_way_ff, rsp_hit_ff};

   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("word taken during clearing pass");

   a_ram_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_LOOK))
      else $error("row written outside clear or lookup");

   a_totals_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (hits_ff >= $past(hits_ff) && misses_ff >= $past(misses_ff)))
      else $error("hit or miss total went backwards");

   a_one_total_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && out_free && hits_ff != '1 && misses_ff != '1)
      |=> ($countones({hits_ff != $past(hits_ff), misses_ff != $past(misses_ff)}) == 1))
      else $error("lookup did not move exactly one total");

endmodule

>>> sv/scas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scas_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/scas_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scas_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scas_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          done,
   input  logic [scas_pkg::DIV_W-1:0]    dividend,
   input  logic [scas_pkg::DVS_W-1:0]    divisor,
   output logic [scas_pkg::DIV_W-1:0]    quotient,
   output logic [scas_pkg::DVS_W-1:0]    remainder
);
   import scas_pkg::*;

   localparam int CW = $clog2(DIV_W + 1);

   logic [CW-1:0]    cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W-1:0] quo_ff,  quo_in;
   logic [DVS_W-1:0] rem_ff,  rem_in;
   logic [DVS_W-1:0] dvs_ff,  dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
